### hdl/fbfl_pkg.sv
// fbfl_pkg.sv: shared constants, codes and types of the block free-list allocator
`timescale 1ns / 1ps
package fbfl_pkg;

   localparam int NUM_BLOCKS_DEF = 1024;
   localparam int IDX_W          = 10;
   localparam int CNT_W          = 11;
   localparam int STATUS_W       = 3;
   localparam int REQ_W          = 2;

   localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
   localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
   localparam logic [REQ_W-1:0] REQ_RESET = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NULL      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_OVERFREE  = 3'd4;

   localparam logic CSR_BLOCK_COUNT = 1'b0;
   localparam logic CSR_SAFE_MODE   = 1'b1;

   localparam logic [CNT_W-1:0] BLOCK_COUNT_RST = 11'd1024;

   typedef struct packed {
      logic             vld;
      logic [IDX_W-1:0] idx;
   } link_type;

   localparam int LINK_W = IDX_W + 1;

endpackage

### hdl/fbfl_ram.sv
// fbfl_ram.sv: generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module fbfl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule

### hdl/fixed_block_free_list_allocator_core.sv
// fixed_block_free_list_allocator_core.sv: fixed-size block pool with a linked free stack
//
// usage
//  - request beat: start high while busy is low; req_type selects allocate, free,
//    pool reset or no-op; req_free_index / req_free_is_null describe a free
//  - response beat: rsp_valid strobes for one cycle with status, allocated index
//    and the free count after the request; every request gives one response
//  - a request passes the input register, then the result register; throughput one
//    request per cycle, as the stack registers take the update of every request
//  - the top two links of the free stack live in registers; the third comes from
//    the link ram, read in the cycle of a pop, so back-to-back pops never wait
//  - csr port: index 0 block count (used at the next pool reset), index 1 safe
//    mode; write only while no request is in flight
//  - reset: the pool comes up full with the reset block count, busy is high
//    while reset is asserted; the link ram needs no clearing pass
//  - the receiver cannot stall; responses are never held back
`timescale 1ns / 1ps
module fixed_block_free_list_allocator_core
   import fbfl_pkg::*;
#(
   parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [REQ_W-1:0]    req_type,
   input  logic [IDX_W-1:0]    req_free_index,
   input  logic                req_free_is_null,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [IDX_W-1:0]    rsp_alloc_index,
   output logic [CNT_W-1:0]    rsp_free_count,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [CNT_W-1:0]    csr_wdata
);

   localparam int CAP     = (NUM_BLOCKS < 1024) ? NUM_BLOCKS : 1024;
   localparam int LINK_AW = $clog2(CAP);
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAP);

   // input register
   logic                 req_vld_ff;
   logic [REQ_W-1:0]     req_type_ff;
   logic [IDX_W-1:0]     req_idx_ff;
   logic                 req_null_ff;

   // configuration
   logic [CNT_W-1:0]     block_count_ff;
   logic                 safe_mode_ff;

   // pool state
   logic [IDX_W-1:0]     head_ff, head_in;
   logic                 nonempty_ff, nonempty_in;
   link_type             hlink_ff, hlink_in;
   link_type             slink_ff, slink_in;
   logic                 use_mem_ff, use_mem_in;
   logic [CNT_W-1:0]     mark_ff, mark_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     pool_ff, pool_in;

   // result register
   logic                 rsp_vld_ff;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic [IDX_W-1:0]     aidx_ff, aidx_in;
   logic [CNT_W-1:0]     rcount_ff;

   // link ram
   logic                 ram_we, ram_re;
   logic [LINK_AW-1:0]   ram_waddr, ram_raddr;
   logic [LINK_W-1:0]    ram_rdata;
   link_type             wlink;
   link_type             slink_cur;
   logic [CNT_W-1:0]     applied_size;
   logic                 idx_beyond_store;

   assign busy = reset;

   fbfl_ram #(
      .WIDTH (LINK_W),
      .DEPTH (CAP)
   ) u_link_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (wlink),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      if (block_count_ff == '0) begin
         applied_size = CNT_W'(1);
      end else if (block_count_ff > CAP_CNT) begin
         applied_size = CAP_CNT;
      end else begin
         applied_size = block_count_ff;
      end
   end

   assign idx_beyond_store = ({22'd0, req_idx_ff} >= 32'(NUM_BLOCKS));
   assign slink_cur        = use_mem_ff ? link_type'(ram_rdata) : slink_ff;
   assign wlink            = '{vld: nonempty_ff, idx: head_ff};

   always_comb begin
      head_in     = head_ff;
      nonempty_in = nonempty_ff;
      hlink_in    = hlink_ff;
      slink_in    = slink_cur;
      use_mem_in  = 1'b0;
      mark_in     = mark_ff;
      count_in    = count_ff;
      pool_in     = pool_ff;
      status_in   = ST_OK;
      aidx_in     = '0;
      ram_we      = 1'b0;
      ram_re      = 1'b0;
      ram_waddr   = req_idx_ff[LINK_AW-1:0];
      ram_raddr   = slink_cur.idx[LINK_AW-1:0];
      if (req_vld_ff) begin
         case (req_type_ff)
            REQ_ALLOC: begin
               if (nonempty_ff) begin
                  // pop: second link moves up, third comes from the ram
                  aidx_in     = head_ff;
                  head_in     = hlink_ff.idx;
                  nonempty_in = hlink_ff.vld;
                  hlink_in    = slink_cur;
                  ram_re      = 1'b1;
                  use_mem_in  = 1'b1;
                  if (count_ff != '0) begin
                     count_in = count_ff - CNT_W'(1);
                  end
               end else if (mark_ff < pool_ff) begin
                  aidx_in = mark_ff[IDX_W-1:0];
                  mark_in = mark_ff + CNT_W'(1);
                  if (count_ff != '0) begin
                     count_in = count_ff - CNT_W'(1);
                  end
               end else begin
                  status_in = ST_EXHAUSTED;
               end
            end
            REQ_FREE: begin
               if (req_null_ff) begin
                  status_in = ST_NULL;
               end else if ((safe_mode_ff && ({1'b0, req_idx_ff} >= pool_ff))
                            || idx_beyond_store) begin
                  status_in = ST_RANGE;
               end else if (count_ff >= pool_ff) begin
                  status_in = ST_OVERFREE;
               end else begin
                  // push: old head becomes second, its link may be the one just written
                  ram_we      = 1'b1;
                  head_in     = req_idx_ff;
                  nonempty_in = 1'b1;
                  hlink_in    = wlink;
                  slink_in    = (req_idx_ff == head_ff) ? wlink : hlink_ff;
                  count_in    = count_ff + CNT_W'(1);
               end
            end
            REQ_RESET: begin
               nonempty_in = 1'b0;
               head_in     = '0;
               mark_in     = '0;
               pool_in     = applied_size;
               count_in    = applied_size;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff     <= 1'b0;
         rsp_vld_ff     <= 1'b0;
         block_count_ff <= BLOCK_COUNT_RST;
         safe_mode_ff   <= 1'b0;
         head_ff        <= '0;
         nonempty_ff    <= 1'b0;
         use_mem_ff     <= 1'b0;
         mark_ff        <= '0;
         count_ff       <= (BLOCK_COUNT_RST > CAP_CNT) ? CAP_CNT : BLOCK_COUNT_RST;
         pool_ff        <= (BLOCK_COUNT_RST > CAP_CNT) ? CAP_CNT : BLOCK_COUNT_RST;
      end else begin
         req_vld_ff  <= start && !busy;
         rsp_vld_ff  <= req_vld_ff;
         head_ff     <= head_in;
         nonempty_ff <= nonempty_in;
         use_mem_ff  <= use_mem_in;
         mark_ff     <= mark_in;
         count_ff    <= count_in;
         pool_ff     <= pool_in;
         if (csr_we) begin
            case (csr_index)
               CSR_BLOCK_COUNT: block_count_ff <= csr_wdata;
               CSR_SAFE_MODE:   safe_mode_ff   <= csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      req_type_ff <= req_type;
      req_idx_ff  <= req_free_index;
      req_null_ff <= req_free_is_null;
      hlink_ff    <= hlink_in;
      slink_ff    <= slink_in;
      status_ff   <= status_in;
      aidx_ff     <= aidx_in;
      rcount_ff   <= count_in;
   end

   assign rsp_valid       = rsp_vld_ff;
   assign rsp_status      = status_ff;
   assign rsp_alloc_index = aidx_ff;
   assign rsp_free_count  = rcount_ff;

endmodule

### hdl/fbfl_checker.sv
// fbfl_checker.sv: port-level checks of the allocator and their bind
`timescale 1ns / 1ps
module fbfl_checker
   import fbfl_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                rsp_valid,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [IDX_W-1:0]    rsp_alloc_index,
   input logic [CNT_W-1:0]    rsp_free_count
);

   // every accepted beat is answered once it has passed the input and result registers
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("request beat without response");

   // no response without an accepted request ahead of it
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("response beat without request");

   // a failed request hands out no block
   a_fail_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_alloc_index == '0))
      else $error("index on failed request");

   // exhausted only when nothing is free
   a_exhausted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_EXHAUSTED) |-> (rsp_free_count == '0))
      else $error("exhausted with free blocks left");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_free_count <= CNT_W'(1024)))
      else $error("free count beyond capacity");

endmodule

bind fixed_block_free_list_allocator_core fbfl_checker u_fbfl_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_status      (rsp_status),
   .rsp_alloc_index (rsp_alloc_index),
   .rsp_free_count  (rsp_free_count)
);

### tb/fbfl_pool_checker.sv
// fbfl_pool_checker.sv: beat monitor, free-list pool predictor and response comparator
`timescale 1ns / 1ps
module fbfl_pool_checker
   import fbfl_pkg::*;
#(
   parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  logic [REQ_W-1:0]    req_type,
   input  logic [IDX_W-1:0]    req_free_index,
   input  logic                req_free_is_null,
   input  logic                rsp_valid,
   input  logic [STATUS_W-1:0] rsp_status,
   input  logic [IDX_W-1:0]    rsp_alloc_index,
   input  logic [CNT_W-1:0]    rsp_free_count,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [CNT_W-1:0]    csr_wdata,
   output int                  errors,
   output int                  pending
);

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [IDX_W-1:0]    alloc_index;
      logic [CNT_W-1:0]    free_count;
   } reply_type;

   localparam int CAPACITY = (NUM_BLOCKS > 1024) ? 1024 : NUM_BLOCKS;

   link_type         links [NUM_BLOCKS];
   logic [IDX_W-1:0] top_block;
   logic             stack_live;
   logic [CNT_W-1:0] fresh_mark;
   logic [CNT_W-1:0] free_blocks;
   logic [CNT_W-1:0] pool_size;
   logic [CNT_W-1:0] block_count;
   logic             safe_mode;
   reply_type        replies_due [$];

   task refill_pool();
      top_block  = '0;
      stack_live = 1'b0;
      fresh_mark = '0;
      if (block_count == 0) begin
         pool_size = CNT_W'(1);
      end else if (block_count > CAPACITY) begin
         pool_size = CNT_W'(CAPACITY);
      end else begin
         pool_size = block_count;
      end
      free_blocks = pool_size;
   endtask

   task serve_request(input logic [REQ_W-1:0] kind, input logic [IDX_W-1:0] fidx,
                      input logic no_block, output reply_type r);
      link_type lk;
      r = '0;
      r.status = ST_OK;
      case (kind)
         REQ_ALLOC: begin
            if (stack_live) begin
               lk = links[top_block];
               r.alloc_index = top_block;
               top_block = lk.idx;
               stack_live = lk.vld;
               if (free_blocks != 0) free_blocks = free_blocks - 1'b1;
            end else if (fresh_mark < pool_size) begin
               r.alloc_index = fresh_mark[IDX_W-1:0];
               fresh_mark = fresh_mark + 1'b1;
               if (free_blocks != 0) free_blocks = free_blocks - 1'b1;
            end else begin
               r.status = ST_EXHAUSTED;
            end
         end
         REQ_FREE: begin
            if (no_block) begin
               r.status = ST_NULL;
            end else if ((safe_mode && fidx >= pool_size) || int'(fidx) >= NUM_BLOCKS) begin
               r.status = ST_RANGE;
            end else if (free_blocks >= pool_size) begin
               r.status = ST_OVERFREE;
            end else begin
               lk.vld = stack_live;
               lk.idx = top_block;
               links[fidx] = lk;
               top_block = fidx;
               stack_live = 1'b1;
               free_blocks = free_blocks + 1'b1;
            end
         end
         REQ_RESET: refill_pool();
         default: ;
      endcase
      r.free_count = free_blocks;
   endtask

   always @(posedge clock) begin
      reply_type want;
      reply_type got;
      if (reset) begin
         block_count = BLOCK_COUNT_RST;
         safe_mode = 1'b0;
         refill_pool();
         replies_due.delete();
      end else begin
         if (rsp_valid) begin
            got = {rsp_status, rsp_alloc_index, rsp_free_count};
            if (replies_due.size() == 0) begin
               $error("response beat with no request outstanding: status %0d index %0d count %0d",
                      got.status, got.alloc_index, got.free_count);
               errors++;
            end else begin
               want = replies_due.pop_front();
               if (got.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, got.status);
                  errors++;
               end
               if (got.alloc_index !== want.alloc_index) begin
                  $error("alloc_index: expected %0d, actual %0d", want.alloc_index,
                         got.alloc_index);
                  errors++;
               end
               if (got.free_count !== want.free_count) begin
                  $error("free_count: expected %0d, actual %0d", want.free_count,
                         got.free_count);
                  errors++;
               end
            end
         end
         if (start && !busy) begin
            serve_request(req_type, req_free_index, req_free_is_null, want);
            replies_due.push_back(want);
         end
         if (csr_we) begin
            if (csr_index == CSR_BLOCK_COUNT) begin
               block_count = csr_wdata;
            end else begin
               safe_mode = csr_wdata[0];
            end
         end
      end
      pending = replies_due.size();
   end

endmodule

### tb/fixed_block_free_list_allocator_core_tb.sv
// fixed_block_free_list_allocator_core_tb.sv: stimulus, pool settings and verdict for the allocator
`timescale 1ns / 1ps
module fixed_block_free_list_allocator_core_tb;
   import fbfl_pkg::*;

   localparam logic [REQ_W-1:0] REQ_NOP = 2'd3;
   localparam int WATCHDOG_LIMIT = 500;
   localparam int PHASE_COUNT    = 10;
   localparam int ITEM_GOAL      = 800;
   localparam int SETTLE_CYCLES  = 4;

   logic                clock = 1'b0;
   logic                reset;
   logic                start;
   logic                busy;
   logic [REQ_W-1:0]    req_type;
   logic [IDX_W-1:0]    req_free_index;
   logic                req_free_is_null;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [IDX_W-1:0]    rsp_alloc_index;
   logic [CNT_W-1:0]    rsp_free_count;
   logic                csr_we;
   logic                csr_index;
   logic [CNT_W-1:0]    csr_wdata;

   int check_errors;
   int check_pending;
   int idle_cycles;
   int sent_count;
   int reply_count;
   int exhausted_seen;
   int overfree_seen;
   int pool_now;

   logic [REQ_W-1:0] kinds_in_flight [$];
   logic [IDX_W-1:0] held_blocks [$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   fixed_block_free_list_allocator_core dut (.*);

   fbfl_pool_checker pool_check (
      .*,
      .errors (check_errors),
      .pending(check_pending)
   );

   // blocks handed out and not yet freed, plus the no-progress watchdog
   always @(posedge clock) begin
      logic [REQ_W-1:0] kind;
      if (!reset) begin
         if (rsp_valid && kinds_in_flight.size() != 0) begin
            kind = kinds_in_flight.pop_front();
            reply_count++;
            if (kind == REQ_ALLOC && rsp_status == ST_OK) held_blocks.push_back(rsp_alloc_index);
            if (kind == REQ_RESET) held_blocks.delete();
            if (rsp_status == ST_EXHAUSTED) exhausted_seen++;
            if (rsp_status == ST_OVERFREE) overfree_seen++;
         end
         if (start && !busy) kinds_in_flight.push_back(req_type);
      end
      if ((start && !busy) || rsp_valid || reset) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("fixed_block_free_list_allocator_core_tb NOT OK");
         $finish;
      end
   end

   task send(input logic [REQ_W-1:0] kind, input logic [IDX_W-1:0] idx, input logic no_block);
      start <= 1'b1;
      req_type <= kind;
      req_free_index <= idx;
      req_free_is_null <= no_block;
      @(posedge clock iff !busy);
      sent_count++;
   endtask

   task pause(input int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task drain();
      start <= 1'b0;
      @(posedge clock);
      while (kinds_in_flight.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task set_config(input logic [CNT_W-1:0] count, input logic safe);
      csr_we <= 1'b1;
      csr_index <= CSR_BLOCK_COUNT;
      csr_wdata <= count;
      @(posedge clock);
      csr_index <= CSR_SAFE_MODE;
      csr_wdata <= {{(CNT_W-1){1'b0}}, safe};
      @(posedge clock);
      csr_we <= 1'b0;
      pool_now = (count == 0) ? 1 : (count > 1024) ? 1024 : int'(count);
   endtask

   task send_random_item(output bit counted);
      int pick;
      int slot;
      logic [IDX_W-1:0] idx;
      pick = $urandom_range(0, 99);
      idx = IDX_W'($urandom_range(0, 1023));
      counted = 1'b1;
      if (pick < 40) begin
         send(REQ_ALLOC, idx, 1'($urandom_range(0, 1)));
      end else if (pick < 74) begin
         // well-formed when a block is out: give back a held block, else any index in the pool
         if (held_blocks.size() != 0) begin
            slot = $urandom_range(0, held_blocks.size() - 1);
            idx = held_blocks[slot];
            held_blocks.delete(slot);
         end else begin
            idx = IDX_W'($urandom_range(0, pool_now - 1));
         end
         send(REQ_FREE, idx, 1'b0);
      end else if (pick < 82) begin
         send(REQ_FREE, idx, 1'b0);
      end else if (pick < 88) begin
         send(REQ_FREE, IDX_W'($urandom_range(0, pool_now - 1)), 1'b0);
      end else if (pick < 94) begin
         send(REQ_FREE, idx, 1'b1);
         counted = 1'b0;
      end else if (pick < 97) begin
         send(REQ_NOP, idx, 1'($urandom_range(0, 1)));
         counted = 1'b0;
      end else begin
         send(REQ_RESET, idx, 1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      int items_left;
      int burst_left;
      bit counted;
      bit gappy;
      logic [CNT_W-1:0] bc;
      logic sm;
      reset = 1'b1;
      start = 1'b0;
      req_type = REQ_ALLOC;
      req_free_index = '0;
      req_free_is_null = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_BLOCK_COUNT;
      csr_wdata = '0;
      pool_now = 1024;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // full pool after reset, safe mode off
      send(REQ_ALLOC, '0, 1'b0);
      send(REQ_ALLOC, '1, 1'b1);
      send(REQ_FREE, 10'd1, 1'b0);
      send(REQ_FREE, '1, 1'b1);
      send(REQ_ALLOC, '0, 1'b0);
      send(REQ_FREE, '1, 1'b0);
      send(REQ_FREE, '0, 1'b0);
      send(REQ_FREE, 10'd5, 1'b0);
      send(REQ_NOP, '1, 1'b1);
      pause(2);
      send(REQ_ALLOC, '0, 1'b0);
      send(REQ_ALLOC, '0, 1'b0);
      send(REQ_ALLOC, '0, 1'b0);
      send(REQ_FREE, 10'd2, 1'b0);
      send(REQ_FREE, 10'd2, 1'b0);
      send(REQ_ALLOC, '0, 1'b0);
      send(REQ_ALLOC, '0, 1'b0);
      send(REQ_RESET, '0, 1'b0);

      // single block pool with range check
      drain();
      set_config(11'd1, 1'b1);
      send(REQ_RESET, '0, 1'b0);
      send(REQ_ALLOC, '0, 1'b0);
      send(REQ_ALLOC, '0, 1'b0);
      send(REQ_FREE, 10'd1, 1'b0);
      send(REQ_FREE, '0, 1'b0);
      send(REQ_FREE, '0, 1'b0);
      send(REQ_FREE, '1, 1'b1);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin bc = 11'd4;    sm = 1'b0; end
            1: begin bc = 11'd1;    sm = 1'b1; end
            2: begin bc = 11'd1024; sm = 1'b1; end
            3: begin bc = 11'd0;    sm = 1'b0; end
            4: begin bc = 11'd2047; sm = 1'b1; end
            5: begin bc = 11'd16;   sm = 1'b0; end
            6: begin bc = 11'd1024; sm = 1'b0; end
            7: begin bc = 11'd3;    sm = 1'b1; end
            default: begin
               bc = CNT_W'($urandom_range(2, 64));
               sm = 1'($urandom_range(0, 1));
            end
         endcase
         drain();
         set_config(bc, sm);
         send(REQ_RESET, '0, 1'b0);
         gappy = (phase % 3 != 1);
         items_left = ITEM_GOAL / PHASE_COUNT;
         burst_left = 0;
         while (items_left > 0) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               if (gappy) pause($urandom_range(1, 6));
            end
            send_random_item(counted);
            burst_left--;
            if (counted) items_left--;
         end
      end

      drain();
      $display("%0d requests over %0d pool settings (sizes 1 to 1024, range check on and off)",
               sent_count, PHASE_COUNT + 2);
      $display("%0d responses compared, %0d exhausted, %0d over-free",
               reply_count, exhausted_seen, overfree_seen);
      if (check_errors == 0 && check_pending == 0) begin
         $display("fixed_block_free_list_allocator_core_tb OK");
      end else begin
         $display("fixed_block_free_list_allocator_core_tb NOT OK");
      end
      $finish;
   end

endmodule

### fixed_block_free_list_allocator_core.f
hdl/fbfl_pkg.sv
hdl/fbfl_ram.sv
hdl/fixed_block_free_list_allocator_core.sv
hdl/fbfl_checker.sv
tb/fbfl_pool_checker.sv
tb/fixed_block_free_list_allocator_core_tb.sv
